// ----- hw/rtl/srlt_pkg.sv -----
// ----------------------------------------------------------------------------
// srlt_pkg
// Shared types and constants for the sensor row level tracker.
// ----------------------------------------------------------------------------
package srlt_pkg;

   localparam int ROWS     = 4;
   localparam int SENSORS  = 7;
   localparam int SIG_W    = 10;
   localparam int ROW_W    = 2;
   localparam int LEVEL_W  = 3;
   localparam int MASK_W   = 4;
   localparam int HOLD_W   = 8;
   localparam int CNT_W    = 4;
   localparam int WATCH_W  = 3;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;

   localparam logic [LEVEL_W-1:0] LEVEL_NONE = 3'd7;
   localparam logic [WATCH_W-1:0] ROW_NONE   = 3'd7;
   localparam logic [MASK_W-1:0]  FULL_MASK  = MASK_W'((1 << ROWS) - 1);
   localparam logic [CNT_W-1:0]   CNT_MAX    = 4'hF;
   localparam logic [HOLD_W-1:0]  HOLD_MAX   = 8'hFF;

   // register reset values
   localparam logic [SIG_W-1:0]  RST_NULL_DEADBAND    = 10'd30;
   localparam logic [SIG_W-1:0]  RST_DETECT_THRESHOLD = 10'd55;
   localparam logic [HOLD_W-1:0] RST_HOLD_LIMIT       = 8'd12;
   localparam logic [CNT_W-1:0]  RST_ARM_COUNT        = 4'd3;
   localparam logic [CNT_W-1:0]  RST_CONFIRM_COUNT    = 4'd2;

   // register word index (byte address / 4)
   typedef enum logic [2:0] {
      REG_NULL_DEADBAND    = 3'd0,
      REG_DETECT_THRESHOLD = 3'd1,
      REG_HOLD_LIMIT       = 3'd2,
      REG_ARM_COUNT        = 3'd3,
      REG_CONFIRM_COUNT    = 3'd4
   } reg_index_type;

   typedef logic [SENSORS-1:0][SIG_W-1:0] signals_type;

   typedef struct packed {
      logic [SIG_W-1:0]  null_deadband;
      logic [SIG_W-1:0]  detect_threshold;
      logic [HOLD_W-1:0] hold_limit;
      logic [CNT_W-1:0]  arm_count;
      logic [CNT_W-1:0]  confirm_count;
   } cfg_type;

   // strongest sensor of one row
   typedef struct packed {
      logic [ROW_W-1:0]   row;
      logic [SIG_W-1:0]   peak;
      logic [LEVEL_W-1:0] idx;
   } pick_type;

   typedef struct packed {
      logic [ROW_W-1:0]   row_out;
      logic [LEVEL_W-1:0] level;
      logic [MASK_W-1:0]  inactive_rows;
      logic               flow_seen;
      logic               detection_finished;
   } result_type;

endpackage

// ----- hw/rtl/sensor_row_level_tracker.sv -----
// Path: a word is registered in the pick stage register, then in the output register on rsp_.
// Throughput: one word per cycle while rsp_stall does not hold the output; seven sensor
// lanes and a merge stage feed the row state update, which sets the rate.
// Reset (synchronous): registers return to their defaults, all rows inactive,
// no watched row, counters and flags clear, both pipeline stages empty.
// ----------------------------------------------------------------------------
// sensor_row_level_tracker
// Finds each row's strongest sensor and tracks magnet detection per row.
// ----------------------------------------------------------------------------
module sensor_row_level_tracker (
   input  logic                          clock,
   input  logic                          reset,
   // input words
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [srlt_pkg::ROW_W-1:0]    req_row,
   input  logic [srlt_pkg::SIG_W-1:0]    req_signal_0,
   input  logic [srlt_pkg::SIG_W-1:0]    req_signal_1,
   input  logic [srlt_pkg::SIG_W-1:0]    req_signal_2,
   input  logic [srlt_pkg::SIG_W-1:0]    req_signal_3,
   input  logic [srlt_pkg::SIG_W-1:0]    req_signal_4,
   input  logic [srlt_pkg::SIG_W-1:0]    req_signal_5,
   input  logic [srlt_pkg::SIG_W-1:0]    req_signal_6,
   // result words
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [srlt_pkg::ROW_W-1:0]    rsp_row_out,
   output logic [srlt_pkg::LEVEL_W-1:0]  rsp_level,
   output logic [srlt_pkg::MASK_W-1:0]   rsp_inactive_rows,
   output logic                          rsp_flow_seen,
   output logic                          rsp_detection_finished,
   // register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [srlt_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [srlt_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [srlt_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import srlt_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          csr_write;
   reg_index_type csr_index;

   signals_type   signals;
   logic [SENSORS-1:0] win;
   pick_type      pick;
   pick_type      s1_pick_ff;
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_load;
   logic          track_ready;
   result_type    rsp;

   // ---- register port ----
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[ADDR_W-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_NULL_DEADBAND:    cfg_in.null_deadband    = csr_pwdata[SIG_W-1:0];
            REG_DETECT_THRESHOLD: cfg_in.detect_threshold = csr_pwdata[SIG_W-1:0];
            REG_HOLD_LIMIT:       cfg_in.hold_limit       = csr_pwdata[HOLD_W-1:0];
            REG_ARM_COUNT:        cfg_in.arm_count        = csr_pwdata[CNT_W-1:0];
            REG_CONFIRM_COUNT:    cfg_in.confirm_count    = csr_pwdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_NULL_DEADBAND:    csr_prdata = DATA_W'(cfg_ff.null_deadband);
         REG_DETECT_THRESHOLD: csr_prdata = DATA_W'(cfg_ff.detect_threshold);
         REG_HOLD_LIMIT:       csr_prdata = DATA_W'(cfg_ff.hold_limit);
         REG_ARM_COUNT:        csr_prdata = DATA_W'(cfg_ff.arm_count);
         REG_CONFIRM_COUNT:    csr_prdata = DATA_W'(cfg_ff.confirm_count);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.null_deadband    <= RST_NULL_DEADBAND;
         cfg_ff.detect_threshold <= RST_DETECT_THRESHOLD;
         cfg_ff.hold_limit       <= RST_HOLD_LIMIT;
         cfg_ff.arm_count        <= RST_ARM_COUNT;
         cfg_ff.confirm_count    <= RST_CONFIRM_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- sensor lanes and merge ----
   assign signals[0] = req_signal_0;
   assign signals[1] = req_signal_1;
   assign signals[2] = req_signal_2;
   assign signals[3] = req_signal_3;
   assign signals[4] = req_signal_4;
   assign signals[5] = req_signal_5;
   assign signals[6] = req_signal_6;

   for (genvar g = 0; g < SENSORS; g++) begin : g_lane
      srlt_lane #(
         .LANE (g)
      ) u_lane (
         .signals (signals),
         .win     (win[g])
      );
   end

   srlt_merge u_merge (
      .signals (signals),
      .win     (win),
      .row     (req_row),
      .pick    (pick)
   );

   // ---- pick stage register ----
   assign req_stall = s1_valid_ff && !track_ready;
   assign s1_load   = req_valid && !req_stall;

   always_comb begin
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (track_ready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_pick_ff <= pick;
      end
   end

   // ---- row state and output register ----
   srlt_track u_track (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pick_valid (s1_valid_ff),
      .pick       (s1_pick_ff),
      .pick_ready (track_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   assign rsp_row_out            = rsp.row_out;
   assign rsp_level              = rsp.level;
   assign rsp_inactive_rows      = rsp.inactive_rows;
   assign rsp_flow_seen          = rsp.flow_seen;
   assign rsp_detection_finished = rsp.detection_finished;

endmodule

// ----- hw/rtl/srlt_lane.sv -----
// ----------------------------------------------------------------------------
// srlt_lane
// One sensor lane: flags whether this sensor is the first strongest of the row.
// ----------------------------------------------------------------------------
module srlt_lane #(
   parameter int LANE = 0
) (
   input  srlt_pkg::signals_type signals,
   output logic                  win
);
   import srlt_pkg::*;

   // beat every earlier sensor strictly, match or beat every later one
   always_comb begin
      win = (signals[LANE] != '0);
      for (int j = 0; j < SENSORS; j++) begin
         if (j < LANE) begin
            win = win & (signals[LANE] > signals[j]);
         end else if (j > LANE) begin
            win = win & (signals[LANE] >= signals[j]);
         end
      end
   end

endmodule

// ----- hw/rtl/srlt_merge.sv -----
// ----------------------------------------------------------------------------
// srlt_merge
// Combines the lane flags into the winning index and its peak value.
// ----------------------------------------------------------------------------
module srlt_merge (
   input  srlt_pkg::signals_type       signals,
   input  logic [srlt_pkg::SENSORS-1:0] win,
   input  logic [srlt_pkg::ROW_W-1:0]  row,
   output srlt_pkg::pick_type          pick
);
   import srlt_pkg::*;

   // at most one lane wins; none means all sensors read zero
   always_comb begin
      pick.row  = row;
      pick.peak = '0;
      pick.idx  = LEVEL_NONE;
      for (int i = 0; i < SENSORS; i++) begin
         if (win[i]) begin
            pick.peak = signals[i];
            pick.idx  = LEVEL_W'(i);
         end
      end
   end

endmodule

// ----- hw/rtl/srlt_track.sv -----
// ----------------------------------------------------------------------------
// srlt_track
// Row state: arming, per-row confirmation, level hold, and the output register.
// ----------------------------------------------------------------------------
module srlt_track (
   input  logic                 clock,
   input  logic                 reset,
   input  srlt_pkg::cfg_type    cfg,
   input  logic                 pick_valid,
   input  srlt_pkg::pick_type   pick,
   output logic                 pick_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output srlt_pkg::result_type rsp
);
   import srlt_pkg::*;

   logic [LEVEL_W-1:0] last_level_ff [ROWS];
   logic [LEVEL_W-1:0] last_level_in [ROWS];
   logic [CNT_W-1:0]   confirm_ff    [ROWS];
   logic [CNT_W-1:0]   confirm_in    [ROWS];
   logic [HOLD_W-1:0]  hold_ff       [ROWS];
   logic [HOLD_W-1:0]  hold_in       [ROWS];
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic [WATCH_W-1:0] watched_ff, watched_in;
   logic [CNT_W-1:0]   arm_ff, arm_in;
   logic               running_ff, running_in;
   logic               done_ff, done_in;
   logic               flow_ff, flow_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   logic               fire;
   logic               in_range;
   logic               hit_strong;
   logic               inactive;
   logic [MASK_W-1:0]  bit_sel;
   logic [CNT_W-1:0]   conf_inc;
   logic [CNT_W-1:0]   arm_inc;
   logic [HOLD_W-1:0]  hold_inc;
   logic [LEVEL_W-1:0] level;

   assign pick_ready = !rsp_valid_ff || !rsp_stall;
   assign fire       = pick_valid && pick_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp        = rsp_ff;

   // next state for the row in this word
   always_comb begin
      last_level_in = last_level_ff;
      confirm_in    = confirm_ff;
      hold_in       = hold_ff;
      mask_in       = mask_ff;
      watched_in    = watched_ff;
      arm_in        = arm_ff;
      running_in    = running_ff;
      done_in       = done_ff;
      flow_in       = flow_ff;
      level         = LEVEL_NONE;
      inactive      = 1'b1;

      in_range   = ({1'b0, pick.row} < 3'(ROWS));
      bit_sel    = MASK_W'(1) << pick.row;
      hit_strong = (pick.peak > cfg.detect_threshold) && (pick.idx > 3'd1)
                   && (pick.idx != LEVEL_NONE);
      conf_inc = (confirm_ff[pick.row] != CNT_MAX) ? confirm_ff[pick.row] + 4'd1
                                                   : confirm_ff[pick.row];
      arm_inc  = (arm_ff != CNT_MAX) ? arm_ff + 4'd1 : arm_ff;
      hold_inc = (hold_ff[pick.row] != HOLD_MAX) ? hold_ff[pick.row] + 8'd1
                                                 : hold_ff[pick.row];

      if (in_range) begin
         // confirmation, arming, or watched-row reset
         if (running_ff) begin
            if (((mask_ff & bit_sel) != '0) && hit_strong) begin
               confirm_in[pick.row] = conf_inc;
               if (conf_inc > cfg.confirm_count) begin
                  mask_in = mask_ff & ~bit_sel;
               end
            end else begin
               confirm_in[pick.row] = '0;
            end
            if ((mask_in & FULL_MASK) == '0) begin
               running_in = 1'b0;
               done_in    = 1'b1;
            end
         end else if (!done_ff && hit_strong) begin
            if (watched_ff == ROW_NONE) begin
               watched_in = {1'b0, pick.row};
               arm_in     = arm_inc;
            end else if (watched_ff == {1'b0, pick.row}) begin
               arm_in = arm_inc;
            end
            if (arm_in > cfg.arm_count) begin
               running_in = 1'b1;
               flow_in    = 1'b1;
            end
         end else if (watched_ff == {1'b0, pick.row}) begin
            arm_in = '0;
         end

         // level with weak-signal hold
         inactive = mask_in[pick.row];
         if ((pick.peak < cfg.null_deadband) && !inactive) begin
            if (hold_inc > cfg.hold_limit) begin
               hold_in[pick.row] = cfg.hold_limit;
               level             = '0;
            end else begin
               hold_in[pick.row] = hold_inc;
               level             = last_level_ff[pick.row];
            end
         end else begin
            hold_in[pick.row] = '0;
            level             = inactive ? LEVEL_NONE : pick.idx;
         end
         last_level_in[pick.row] = level;
      end

      rsp_in.row_out            = pick.row;
      rsp_in.level              = level;
      rsp_in.inactive_rows      = mask_in;
      rsp_in.flow_seen          = flow_in;
      rsp_in.detection_finished = done_in;
   end

   // output valid: set on load, cleared when taken
   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control and row state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROWS; i++) begin
            last_level_ff[i] <= '0;
            confirm_ff[i]    <= '0;
            hold_ff[i]       <= '0;
         end
         mask_ff      <= FULL_MASK;
         watched_ff   <= ROW_NONE;
         arm_ff       <= '0;
         running_ff   <= 1'b0;
         done_ff      <= 1'b0;
         flow_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            last_level_ff <= last_level_in;
            confirm_ff    <= confirm_in;
            hold_ff       <= hold_in;
            mask_ff       <= mask_in;
            watched_ff    <= watched_in;
            arm_ff        <= arm_in;
            running_ff    <= running_in;
            done_ff       <= done_in;
            flow_ff       <= flow_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- dv/tb_sensor_row_level_tracker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sensor_row_level_tracker
// Drives row words of seven sensor magnitudes into the level tracker and checks
// each result word against a directed table entry or an in-bench copy of the row
// tracking rules: peak pick, arming on the watched row, per-row confirmation and
// hold of the last level. A short directed table comes first, then random sequences
// under several register settings, with random idling on both sides but in the last.
// ----------------------------------------------------------------------------
module tb_sensor_row_level_tracker;
   import srlt_pkg::*;

   localparam int IDLE_LIMIT = 3000;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      signals_type      sig;
   } sample_row_type;

   typedef struct {
      sample_row_type word;
      bit             typed;
      result_type     want;
   } dir_row_type;

   typedef enum {KIND_STRONG, KIND_WEAK, KIND_NOISE} stim_kind_type;

   // DUT ports
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [ROW_W-1:0]     req_row = '0;
   logic [SIG_W-1:0]     req_signal_0 = '0;
   logic [SIG_W-1:0]     req_signal_1 = '0;
   logic [SIG_W-1:0]     req_signal_2 = '0;
   logic [SIG_W-1:0]     req_signal_3 = '0;
   logic [SIG_W-1:0]     req_signal_4 = '0;
   logic [SIG_W-1:0]     req_signal_5 = '0;
   logic [SIG_W-1:0]     req_signal_6 = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [ROW_W-1:0]     rsp_row_out;
   logic [LEVEL_W-1:0]   rsp_level;
   logic [MASK_W-1:0]    rsp_inactive_rows;
   logic                 rsp_flow_seen;
   logic                 rsp_detection_finished;
   logic                 csr_psel = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]    csr_paddr = '0;
   logic [DATA_W-1:0]    csr_pwdata = '0;
   logic [DATA_W-1:0]    csr_prdata;
   logic                 csr_pready;

   // tracker copy: registers and per-row state
   cfg_type              cfg;
   logic [LEVEL_W-1:0]   last_lvl [ROWS];
   logic [CNT_W-1:0]     conf_cnt [ROWS];
   logic [HOLD_W-1:0]    hold_cnt [ROWS];
   logic [MASK_W-1:0]    nomag;
   logic [WATCH_W-1:0]   watch;
   logic [CNT_W-1:0]     arm_cnt;
   bit                   running, done, flow;

   result_type           pending_levels [$];
   dir_row_type          dir_rows [$];
   bit                   idle_on = 1'b1;
   int                   stall_left = 0;
   int                   idle_cycles = 0;
   int                   words_sent = 0;
   int                   results_checked = 0;
   int                   mismatch_count = 0;
   int                   settings_applied = 0;
   int                   forced_zero_count = 0;
   result_type           seen, want;

   sensor_row_level_tracker i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_row                (req_row),
      .req_signal_0           (req_signal_0),
      .req_signal_1           (req_signal_1),
      .req_signal_2           (req_signal_2),
      .req_signal_3           (req_signal_3),
      .req_signal_4           (req_signal_4),
      .req_signal_5           (req_signal_5),
      .req_signal_6           (req_signal_6),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_row_out            (rsp_row_out),
      .rsp_level              (rsp_level),
      .rsp_inactive_rows      (rsp_inactive_rows),
      .rsp_flow_seen          (rsp_flow_seen),
      .rsp_detection_finished (rsp_detection_finished),
      .csr_psel               (csr_psel),
      .csr_penable            (csr_penable),
      .csr_pwrite             (csr_pwrite),
      .csr_paddr              (csr_paddr),
      .csr_pwdata             (csr_pwdata),
      .csr_prdata             (csr_prdata),
      .csr_pready             (csr_pready)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Level tracking: one row word in, the expected result word out
   // ------------------------------------------------------------------------
   function automatic result_type track_row(input sample_row_type w);
      logic [SIG_W-1:0]   peak;
      logic [LEVEL_W-1:0] idx, lvl;
      logic [ROW_W-1:0]   r;
      logic [MASK_W-1:0]  row_bit;
      bit                 hit_strong, inactive;
      peak = '0;
      idx  = LEVEL_NONE;
      r    = w.row;
      // first strongest sensor wins, later ties do not
      for (int i = 0; i < SENSORS; i++) begin
         if (w.sig[i] > peak) begin
            peak = w.sig[i];
            idx  = LEVEL_W'(i);
         end
      end
      row_bit    = MASK_W'(1) << r;
      hit_strong = (peak > cfg.detect_threshold) && (idx > 1) && (idx != LEVEL_NONE);

      if (running) begin
         // per-row confirmation
         if ((nomag & row_bit) != 0 && hit_strong) begin
            if (conf_cnt[r] != CNT_MAX) conf_cnt[r]++;
            if (conf_cnt[r] > cfg.confirm_count) nomag &= ~row_bit;
         end else begin
            conf_cnt[r] = '0;
         end
         if ((nomag & FULL_MASK) == 0) begin
            running = 1'b0;
            done    = 1'b1;
         end
      end else if (!done && hit_strong) begin
         // arming on the watched row
         if (watch == ROW_NONE) begin
            watch = WATCH_W'(r);
            if (arm_cnt != CNT_MAX) arm_cnt++;
         end else if (watch == WATCH_W'(r)) begin
            if (arm_cnt != CNT_MAX) arm_cnt++;
         end
         if (arm_cnt > cfg.arm_count) begin
            running = 1'b1;
            flow    = 1'b1;
         end
      end else if (watch == WATCH_W'(r)) begin
         arm_cnt = '0;
      end

      // weak peak on an active row repeats the last level until the hold runs out
      inactive = (nomag & row_bit) != 0;
      if (peak < cfg.null_deadband && !inactive) begin
         if (hold_cnt[r] != HOLD_MAX) hold_cnt[r]++;
         if (hold_cnt[r] > cfg.hold_limit) begin
            hold_cnt[r] = cfg.hold_limit;
            lvl = '0;
            forced_zero_count++;
         end else begin
            lvl = last_lvl[r];
         end
      end else begin
         hold_cnt[r] = '0;
         lvl = inactive ? LEVEL_NONE : idx;
      end
      last_lvl[r] = lvl;
      return {r, lvl, nomag, flow, done};
   endfunction

   function automatic result_type res(input logic [ROW_W-1:0] r, input logic [LEVEL_W-1:0] l,
                                      input logic [MASK_W-1:0] m, input logic f,
                                      input logic d);
      return {r, l, m, f, d};
   endfunction

   function automatic signals_type sig_at(input int i, input int v);
      signals_type s;
      s    = '0;
      s[i] = SIG_W'(v);
      return s;
   endfunction

   function automatic void add_dir(input logic [ROW_W-1:0] r, input signals_type s,
                                   input bit typed, input result_type exp_word);
      dir_row_type t;
      t.word.row = r;
      t.word.sig = s;
      t.typed    = typed;
      t.want     = exp_word;
      dir_rows.push_back(t);
   endfunction

   // random row word of one kind, shaped by the current thresholds
   function automatic sample_row_type mk_word(input stim_kind_type kind,
                                              input logic [ROW_W-1:0] r);
      sample_row_type w;
      int             pk, lo, wi;
      w.row = r;
      w.sig = '0;
      case (kind)
         KIND_STRONG: begin
            wi = $urandom_range(2, SENSORS - 1);
            lo = (cfg.detect_threshold == '1) ? 1023 : int'(cfg.detect_threshold) + 1;
            pk = $urandom_range(lo, 1023);
            for (int i = 0; i < SENSORS; i++) begin
               if (i < wi) w.sig[i] = SIG_W'($urandom_range(0, pk - 1));
               else if (i > wi) w.sig[i] = SIG_W'($urandom_range(0, pk));
               else w.sig[i] = SIG_W'(pk);
            end
         end
         KIND_WEAK: begin
            for (int i = 0; i < SENSORS; i++)
               w.sig[i] = (cfg.null_deadband == 0) ? '0 :
                          SIG_W'($urandom_range(0, int'(cfg.null_deadband) - 1));
         end
         default: begin
            case ($urandom_range(0, 4))
               0: w.sig = '0;
               1: w.sig = '1;
               2: begin
                  wi = $urandom_range(0, 1);
                  w.sig[wi] = SIG_W'($urandom_range(1, 1023));
               end
               default: begin
                  for (int i = 0; i < SENSORS; i++) w.sig[i] = SIG_W'($urandom);
               end
            endcase
         end
      endcase
      return w;
   endfunction

   task automatic note_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("MISMATCH: %s", msg);
   endtask

   // ------------------------------------------------------------------------
   // Input side: one word, with an optional gap before it
   // ------------------------------------------------------------------------
   task automatic send_word(input sample_row_type w, input bit typed,
                            input result_type exp_word);
      result_type model;
      int         n;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         n = $urandom_range(1, 13);
         repeat (n) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_row      <= w.row;
      req_signal_0 <= w.sig[0];
      req_signal_1 <= w.sig[1];
      req_signal_2 <= w.sig[2];
      req_signal_3 <= w.sig[3];
      req_signal_4 <= w.sig[4];
      req_signal_5 <= w.sig[5];
      req_signal_6 <= w.sig[6];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      model = track_row(w);
      pending_levels.push_back(typed ? exp_word : model);
      words_sent++;
   endtask

   // stop sending and let every expected result arrive
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Register port: setup then access, one transfer
   // ------------------------------------------------------------------------
   task automatic csr_xfer(input reg_index_type idx, input bit wr, input logic [DATA_W-1:0] wdata,
                           output logic [DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // write with junk above the field width, then read back the masked value
   task automatic write_check(input reg_index_type idx, input logic [DATA_W-1:0] val,
                              input logic [DATA_W-1:0] wmask, input logic [DATA_W-1:0] junk);
      logic [DATA_W-1:0] rd;
      csr_xfer(idx, 1'b1, (val & wmask) | (junk & ~wmask), rd);
      csr_xfer(idx, 1'b0, '0, rd);
      if (rd !== (val & wmask))
         note_error($sformatf("register %s read %h, expected %h", idx.name(), rd, val & wmask));
   endtask

   task automatic set_config(input cfg_type c, input logic [DATA_W-1:0] junk);
      write_check(REG_NULL_DEADBAND,    DATA_W'(c.null_deadband),    32'h3FF, junk);
      write_check(REG_DETECT_THRESHOLD, DATA_W'(c.detect_threshold), 32'h3FF, junk);
      write_check(REG_HOLD_LIMIT,       DATA_W'(c.hold_limit),       32'hFF,  junk);
      write_check(REG_ARM_COUNT,        DATA_W'(c.arm_count),        32'hF,   junk);
      write_check(REG_CONFIRM_COUNT,    DATA_W'(c.confirm_count),    32'hF,   junk);
      cfg = c;
      settings_applied++;
   endtask

   // ------------------------------------------------------------------------
   // Random sequences: mostly runs of strong hits on one row followed by weak
   // words, plus weak bursts and noise; long_hold starts with a weak run long
   // enough to reach the hold counter ceiling
   // ------------------------------------------------------------------------
   task automatic run_phase(input int n, input bit long_hold, input bit bias);
      int               target, mode, len;
      logic [ROW_W-1:0] r;
      target = words_sent + n;
      if (long_hold) begin
         r = $urandom_range(0, ROWS - 1);
         repeat (300) send_word(mk_word(KIND_WEAK, r), 1'b0, '0);
      end
      while (words_sent < target) begin
         r    = (bias && $urandom_range(0, 3) != 0) ? '0 : ROW_W'($urandom_range(0, ROWS - 1));
         mode = $urandom_range(0, 9);
         if (mode < 6) begin
            len = $urandom_range(1, 16);
            repeat (len)
               send_word(mk_word(($urandom_range(0, 5) == 0) ? KIND_NOISE : KIND_STRONG, r),
                         1'b0, '0);
            len = $urandom_range(1, 4);
            repeat (len) send_word(mk_word(KIND_WEAK, r), 1'b0, '0);
         end else if (mode < 8) begin
            len = $urandom_range(1, 20);
            repeat (len) send_word(mk_word(KIND_WEAK, r), 1'b0, '0);
         end else begin
            len = $urandom_range(1, 4);
            repeat (len)
               send_word(mk_word(KIND_NOISE, ROW_W'($urandom_range(0, ROWS - 1))), 1'b0, '0);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side: random stall bursts
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!idle_on) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 13) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each accepted result word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_row_out, rsp_level, rsp_inactive_rows, rsp_flow_seen,
                 rsp_detection_finished};
         results_checked++;
         if (pending_levels.size() == 0) begin
            note_error($sformatf("unexpected result row %0d level %0d mask %h flow %0b done %0b",
                                 seen.row_out, seen.level, seen.inactive_rows, seen.flow_seen,
                                 seen.detection_finished));
         end else begin
            want = pending_levels.pop_front();
            if (seen.row_out !== want.row_out || seen.level !== want.level ||
                seen.inactive_rows !== want.inactive_rows ||
                seen.flow_seen !== want.flow_seen ||
                seen.detection_finished !== want.detection_finished)
               note_error($sformatf({"result %0d: expected row %0d level %0d mask %h flow %0b ",
                                     "done %0b, got row %0d level %0d mask %h flow %0b done %0b"},
                                    results_checked, want.row_out, want.level,
                                    want.inactive_rows, want.flow_seen, want.detection_finished,
                                    seen.row_out, seen.level, seen.inactive_rows,
                                    seen.flow_seen, seen.detection_finished));
         end
      end
   end

   // watchdog: cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("** sensor_row_level_tracker: FAILED **");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      cfg     = {RST_NULL_DEADBAND, RST_DETECT_THRESHOLD, RST_HOLD_LIMIT, RST_ARM_COUNT,
                 RST_CONFIRM_COUNT};
      nomag   = FULL_MASK;
      watch   = ROW_NONE;
      arm_cnt = '0;
      running = 1'b0;
      done    = 1'b0;
      flow    = 1'b0;
      for (int i = 0; i < ROWS; i++) begin
         last_lvl[i] = '0;
         conf_cnt[i] = '0;
         hold_cnt[i] = '0;
      end

      // directed table, reset register values
      add_dir(0, '0,                              1, res(0, LEVEL_NONE, 4'hF, 0, 0));
      add_dir(1, '1,                              1, res(1, LEVEL_NONE, 4'hF, 0, 0));
      add_dir(2, sig_at(6, 1023),                 1, res(2, LEVEL_NONE, 4'hF, 0, 0));
      // tie: the lower sensor keeps the win
      add_dir(3, sig_at(3, 500) | sig_at(5, 500), 1, res(3, LEVEL_NONE, 4'hF, 0, 0));
      add_dir(2, sig_at(2, 56),                   1, res(2, LEVEL_NONE, 4'hF, 0, 0));
      // peak equal to the threshold breaks the arming run
      add_dir(2, sig_at(4, 55),                   1, res(2, LEVEL_NONE, 4'hF, 0, 0));
      repeat (3) add_dir(2, sig_at(5, 300),       1, res(2, LEVEL_NONE, 4'hF, 0, 0));
      add_dir(2, sig_at(5, 300),                  1, res(2, LEVEL_NONE, 4'hF, 1, 0));
      repeat (2) add_dir(0, sig_at(0, 1022) | sig_at(6, 1023), 1,
                         res(0, LEVEL_NONE, 4'hF, 1, 0));
      add_dir(0, sig_at(0, 1022) | sig_at(6, 1023), 1, res(0, 3'd6, 4'hE, 1, 0));
      // all zero on an active row holds the last level
      add_dir(0, '0,                              1, res(0, 3'd6, 4'hE, 1, 0));
      add_dir(0, sig_at(1, 29),                   1, res(0, 3'd6, 4'hE, 1, 0));
      add_dir(0, sig_at(1, 30),                   1, res(0, 3'd1, 4'hE, 1, 0));
      add_dir(0, sig_at(0, 1023) | sig_at(1, 1023), 1, res(0, 3'd0, 4'hE, 1, 0));
      add_dir(1, sig_at(3, 1023),                 1, res(1, LEVEL_NONE, 4'hE, 1, 0));
      add_dir(1, sig_at(1, 1023),                 1, res(1, LEVEL_NONE, 4'hE, 1, 0));
      add_dir(1, sig_at(3, 100) | sig_at(6, 99),  0, '0);
      add_dir(3, sig_at(2, 1023) | sig_at(4, 7),  0, '0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
      drain();

      // slow confirmation, arm and confirm counts of 14
      set_config({10'd100, 10'd300, 8'd6, 4'd14, 4'd14}, '0);
      run_phase(450, 1'b0, 1'b0);
      drain();
      // lowest settings: any high peak confirms, no hold
      set_config({10'd0, 10'd0, 8'd0, 4'd0, 4'd0}, '0);
      run_phase(300, 1'b0, 1'b0);
      drain();
      // highest settings: nothing is strong, hold count runs to its ceiling
      set_config({10'd1023, 10'd1023, 8'd255, 4'd14, 4'd14}, '0);
      run_phase(150, 1'b1, 1'b1);
      drain();
      // short hold: level forced to zero often
      set_config({10'd200, 10'd500, 8'd1, 4'd5, 4'd1}, '0);
      run_phase(400, 1'b0, 1'b0);
      drain();
      // random settings, no idling on either side
      idle_on = 1'b0;
      set_config({SIG_W'($urandom), SIG_W'($urandom), HOLD_W'($urandom),
                  CNT_W'($urandom_range(0, 14)), CNT_W'($urandom_range(0, 14))}, $urandom);
      run_phase(400, 1'b0, 1'b0);
      drain();
      repeat (8) @(posedge clock);

      $display("Sent %0d row words under %0d register settings, checked %0d results.",
               words_sent, settings_applied + 1, results_checked);
      $display("Rows left inactive: %h, detection finished: %0b, hold forced level 0 %0d times.",
               nomag, done, forced_zero_count);
      if (mismatch_count == 0)
         $display("** sensor_row_level_tracker: PASSED **");
      else
         $display("** sensor_row_level_tracker: FAILED **");
      $finish;
   end

endmodule
